// File: design/clrt_pkg.sv
// Shared types, codes and constants of the countdown LED ring timer.
// Used by clrt_div, clrt_ring and countdown_led_ring_timer_top; no dependencies.
`timescale 1ns / 1ps

package clrt_pkg;

  // Field widths
  localparam int TIME_W    = 31;
  localparam int PERIOD_W  = 16;
  localparam int INDEX_W   = 6;
  localparam int COLOUR_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Scale PIXELS*MAX_LEVEL tops out at 64*255 = 16320, which fits 14 bits
  localparam int QUOT_W  = 14;
  localparam int PROD_W  = QUOT_W + PERIOD_W;
  // Running total: at most 16320, at least about -650 after the clamp floor
  localparam int TOTAL_W = 16;

  localparam int MIN_LEVEL = 10;

  // Defaults of the top-level parameters
  localparam int PIXELS_DEF    = 16;
  localparam int MAX_LEVEL_DEF = 255;

  // Reset values of the period registers, in seconds
  localparam logic [PERIOD_W-1:0] LONG_RESET   = PERIOD_W'(30 * 60);
  localparam logic [PERIOD_W-1:0] SHORT_RESET  = PERIOD_W'(5 * 60);
  localparam logic [PERIOD_W-1:0] MEDIUM_RESET = PERIOD_W'(15 * 60);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  // Period slots, also the colour selector
  localparam logic [1:0] SLOT_LONG   = 2'd0;
  localparam logic [1:0] SLOT_SHORT  = 2'd1;
  localparam logic [1:0] SLOT_MEDIUM = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd2;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT,
    ST_MSG
  } state_t;

  // Command from the sequencer to the ring emitter
  typedef struct packed {
    logic              load_pix;
    logic              load_msg;
    logic              status;
    logic              clr;
    logic [1:0]        slot;
    logic [QUOT_W-1:0] total;
  } ring_cmd_t;

  // Status from the ring emitter
  typedef struct packed {
    logic busy;
    logic slot_free;
  } ring_stat_t;

endpackage

// File: design/clrt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on clrt_pkg for the dividend, divisor and quotient widths.
`timescale 1ns / 1ps

module clrt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [clrt_pkg::PROD_W-1:0]      dividend,
  input  logic [clrt_pkg::PERIOD_W-1:0]    divisor,
  output logic                             done,
  output logic [clrt_pkg::QUOT_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(clrt_pkg::PROD_W + 1);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic [clrt_pkg::PERIOD_W-1:0]   dvs;
  logic [clrt_pkg::PERIOD_W-1:0]   rem;
  logic [clrt_pkg::PROD_W-1:0]     dq;
  logic [clrt_pkg::PERIOD_W:0]     trial;
  logic                            ge;
  logic [clrt_pkg::PERIOD_W:0]     diff;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dq[clrt_pkg::PROD_W-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  // Control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(clrt_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient shifts in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[clrt_pkg::PERIOD_W-1:0] : trial[clrt_pkg::PERIOD_W-1:0];
      dq  <= {dq[clrt_pkg::PROD_W-2:0], ge};
    end
  end

  assign quotient = dq[clrt_pkg::QUOT_W-1:0];

endmodule

// File: design/clrt_ring.sv
// Ring emitter: walks the pixels from the top index down, one per cycle
// while the result slot is free, and holds the output register of the result channel. Depends on clrt_pkg.
`timescale 1ns / 1ps

module clrt_ring #(
  parameter int PIXELS    = clrt_pkg::PIXELS_DEF,
  parameter int MAX_LEVEL = clrt_pkg::MAX_LEVEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clrt_pkg::ring_cmd_t               cmd,
  output clrt_pkg::ring_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic                              clear_ring,
  output logic                              pixel_valid,
  output logic [clrt_pkg::INDEX_W-1:0]      pixel_index,
  output logic [clrt_pkg::COLOUR_W-1:0]     red,
  output logic [clrt_pkg::COLOUR_W-1:0]     green,
  output logic [clrt_pkg::COLOUR_W-1:0]     blue,
  output logic                              last
);

  localparam logic [clrt_pkg::INDEX_W-1:0] TOP_INDEX = clrt_pkg::INDEX_W'(PIXELS - 1);
  localparam logic signed [clrt_pkg::TOTAL_W-1:0] MIN_S =
    clrt_pkg::TOTAL_W'(clrt_pkg::MIN_LEVEL);
  localparam logic signed [clrt_pkg::TOTAL_W-1:0] MAX_S = clrt_pkg::TOTAL_W'(MAX_LEVEL);

  logic                                  active;
  logic [clrt_pkg::INDEX_W-1:0]          cnt;
  logic signed [clrt_pkg::TOTAL_W-1:0]   total;
  logic [1:0]                            slot;
  logic                                  slot_free;
  logic [clrt_pkg::COLOUR_W-1:0]         level;

  assign slot_free      = !out_valid || out_ready;
  assign stat.busy      = active;
  assign stat.slot_free = slot_free;

  // Clamp the running total into the visible range
  always_comb begin
    if (total < MIN_S) begin
      level = clrt_pkg::COLOUR_W'(clrt_pkg::MIN_LEVEL);
    end else if (total > MAX_S) begin
      level = clrt_pkg::COLOUR_W'(MAX_LEVEL);
    end else begin
      level = total[clrt_pkg::COLOUR_W-1:0];
    end
  end

  // Control: pixel walk and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_pix) begin
        active <= 1'b1;
      end else if (active && slot_free && cnt == '0) begin
        active <= 1'b0;
      end
      if (cmd.load_msg || (active && slot_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: running total, pixel counter and the result register
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      total <= $signed({2'b00, cmd.total});
      slot  <= cmd.slot;
      cnt   <= TOP_INDEX;
    end else if (active && slot_free) begin
      total <= total - $signed({{(clrt_pkg::TOTAL_W - clrt_pkg::COLOUR_W){1'b0}}, level});
      cnt   <= cnt - 1'b1;
    end

    if (cmd.load_msg) begin
      status      <= cmd.status;
      clear_ring  <= cmd.clr;
      pixel_valid <= 1'b0;
      pixel_index <= '0;
      red         <= '0;
      green       <= '0;
      blue        <= '0;
      last        <= 1'b1;
    end else if (active && slot_free) begin
      status      <= 1'b0;
      clear_ring  <= 1'b0;
      pixel_valid <= 1'b1;
      pixel_index <= cnt;
      red         <= (slot == clrt_pkg::SLOT_SHORT) ? level : '0;
      green       <= (slot != clrt_pkg::SLOT_LONG && slot != clrt_pkg::SLOT_SHORT) ?
                     level : '0;
      blue        <= (slot == clrt_pkg::SLOT_LONG) ? level : '0;
      last        <= (cnt == '0);
    end
  end

endmodule

// File: design/countdown_led_ring_timer_top.sv
// Countdown LED ring timer: top level with timer state, period registers and
// the control sequencer. Depends on clrt_pkg, clrt_div and clrt_ring.
//
// Usage:
//  - Input channel (in_valid/in_ready): one item carries kind, now_seconds and
//    length_select. A tick or an accepted start redraws the ring as PIXELS
//    pixel results, top index first; a refused start, a stop, or a tick that
//    drops an active timer gives one result without a pixel. An idle tick and
//    kind three give nothing.
//  - Result channel (out_valid/out_ready): driven from an output register;
//    last marks the final result of an item.
//  - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
//    ready; indexes 0..2 hold the long, short and medium periods.
//  - Sequencing: a redraw passes through ST_MUL (the scaled product), ST_DIVGO
//    (divider start), ST_DIV and the ring load, then emits its pixels in ST_EMIT;
//    single-result items wait in ST_MSG for a free result slot and an idle ring.
//    Items are taken one at a time: the input is ready only in ST_IDLE.
//  - A stalled receiver holds the current result and pauses the pixel walk;
//    nothing is dropped.
//  - Reset clears the timer to inactive and loads the default periods.
`timescale 1ns / 1ps

module countdown_led_ring_timer_top #(
  parameter int PIXELS    = clrt_pkg::PIXELS_DEF,
  parameter int MAX_LEVEL = clrt_pkg::MAX_LEVEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [clrt_pkg::TIME_W-1:0]       now_seconds,
  input  logic [1:0]                        length_select,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic                              clear_ring,
  output logic                              pixel_valid,
  output logic [clrt_pkg::INDEX_W-1:0]      pixel_index,
  output logic [clrt_pkg::COLOUR_W-1:0]     red,
  output logic [clrt_pkg::COLOUR_W-1:0]     green,
  output logic [clrt_pkg::COLOUR_W-1:0]     blue,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clrt_pkg::PERIOD_W-1:0]     cfg_data
);

  localparam int SCALE = PIXELS * MAX_LEVEL;

  clrt_pkg::state_t                 state, state_next;
  clrt_pkg::ring_cmd_t              cmd;
  clrt_pkg::ring_stat_t             stat;

  logic [clrt_pkg::PERIOD_W-1:0]    long_period, short_period, medium_period;
  logic                             running;
  logic [clrt_pkg::TIME_W-1:0]      begin_time, end_time;
  logic [clrt_pkg::PERIOD_W-1:0]    active_period;
  logic [1:0]                       active_slot;

  logic [clrt_pkg::PERIOD_W-1:0]    remain;
  logic [clrt_pkg::PROD_W-1:0]      prod;
  logic                             msg_status, msg_clr;

  logic                             accept;
  logic                             in_window;
  logic [clrt_pkg::TIME_W-1:0]      elapsed;
  logic [clrt_pkg::PERIOD_W-1:0]    sel_period;
  logic [clrt_pkg::TIME_W:0]        end_sum;
  logic                             refuse;

  logic                             div_start;
  logic                             div_done;
  logic [clrt_pkg::QUOT_W-1:0]      quotient;

  assign in_ready  = (state == clrt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Decode the incoming item against the timer state
  always_comb begin
    in_window = running && (now_seconds >= begin_time) && (now_seconds <= end_time) &&
                (active_period != '0);
    elapsed   = now_seconds - begin_time;
    case (length_select)
      clrt_pkg::SLOT_LONG:   sel_period = long_period;
      clrt_pkg::SLOT_SHORT:  sel_period = short_period;
      clrt_pkg::SLOT_MEDIUM: sel_period = medium_period;
      default:               sel_period = '0;
    endcase
    end_sum = {1'b0, now_seconds} + (clrt_pkg::TIME_W + 1)'(sel_period);
    refuse  = running || (sel_period == '0) || end_sum[clrt_pkg::TIME_W];
  end

  // Period registers and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      long_period   <= clrt_pkg::LONG_RESET;
      short_period  <= clrt_pkg::SHORT_RESET;
      medium_period <= clrt_pkg::MEDIUM_RESET;
      running       <= 1'b0;
      begin_time    <= '0;
      end_time      <= '0;
      active_period <= '0;
      active_slot   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          clrt_pkg::REG_LONG:   long_period   <= cfg_data;
          clrt_pkg::REG_SHORT:  short_period  <= cfg_data;
          clrt_pkg::REG_MEDIUM: medium_period <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        case (kind)
          clrt_pkg::KIND_TICK: begin
            if (!in_window) begin
              running       <= 1'b0;
              begin_time    <= '0;
              end_time      <= '0;
              active_period <= '0;
              active_slot   <= '0;
            end
          end
          clrt_pkg::KIND_START: begin
            if (!refuse) begin
              running       <= 1'b1;
              begin_time    <= now_seconds;
              end_time      <= end_sum[clrt_pkg::TIME_W-1:0];
              active_period <= sel_period;
              active_slot   <= length_select;
            end
          end
          clrt_pkg::KIND_STOP: begin
            running       <= 1'b0;
            begin_time    <= '0;
            end_time      <= '0;
            active_period <= '0;
            active_slot   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Hold the remaining time, the scaled product and the pending message
  always_ff @(posedge clk) begin
    if (accept) begin
      remain     <= (kind == clrt_pkg::KIND_START) ? sel_period :
                    active_period - elapsed[clrt_pkg::PERIOD_W-1:0];
      msg_status <= (kind == clrt_pkg::KIND_START);
      msg_clr    <= (kind != clrt_pkg::KIND_START) && running;
    end
    if (state == clrt_pkg::ST_MUL) begin
      prod <= clrt_pkg::PROD_W'(SCALE) * clrt_pkg::PROD_W'(remain);
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and commands
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    cmd        = '0;
    cmd.status = msg_status;
    cmd.clr    = msg_clr;
    cmd.slot   = active_slot;
    cmd.total  = quotient;
    case (state)
      clrt_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            clrt_pkg::KIND_TICK: begin
              if (in_window) begin
                state_next = clrt_pkg::ST_MUL;
              end else if (running) begin
                state_next = clrt_pkg::ST_MSG;
              end
            end
            clrt_pkg::KIND_START: begin
              state_next = refuse ? clrt_pkg::ST_MSG : clrt_pkg::ST_MUL;
            end
            clrt_pkg::KIND_STOP: state_next = clrt_pkg::ST_MSG;
            default: ;
          endcase
        end
      end
      clrt_pkg::ST_MUL:   state_next = clrt_pkg::ST_DIVGO;
      clrt_pkg::ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = clrt_pkg::ST_DIV;
      end
      clrt_pkg::ST_DIV: begin
        if (div_done) begin
          cmd.load_pix = 1'b1;
          state_next   = clrt_pkg::ST_EMIT;
        end
      end
      clrt_pkg::ST_EMIT: begin
        if (!stat.busy) begin
          state_next = clrt_pkg::ST_IDLE;
        end
      end
      clrt_pkg::ST_MSG: begin
        if (stat.slot_free && !stat.busy) begin
          cmd.load_msg = 1'b1;
          state_next   = clrt_pkg::ST_IDLE;
        end
      end
      default: state_next = clrt_pkg::ST_IDLE;
    endcase
  end

  clrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (active_period),
    .done     (div_done),
    .quotient (quotient)
  );

  clrt_ring #(
    .PIXELS    (PIXELS),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .clear_ring  (clear_ring),
    .pixel_valid (pixel_valid),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last        (last)
  );

endmodule
